// ===== src/pscb_pkg.sv =====
// Shared types, constants and the divider step function for the pixel shade blend.
`default_nettype none

package pscb_pkg;

  localparam int unsigned CHANNELS_DEF   = 4;
  localparam int unsigned CH_W           = 8;
  localparam int unsigned PIX_W          = 32;
  localparam int unsigned PIX_CHANNELS   = PIX_W / CH_W;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned NUM_W          = 2 * CH_W;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = NUM_W / BITS_PER_STAGE;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE     = 2'd0,
    MODE_SHADE    = 2'd1,
    MODE_SPECULAR = 2'd2,
    MODE_BOTH     = 2'd3
  } mode_e;

  // Per-stage load strobes and occupancy; index DIV_STAGES is the output register.
  typedef struct packed {
    logic [DIV_STAGES:0] load;
    logic [DIV_STAGES:0] valid;
  } pipe_ctl_t;

  typedef struct packed {
    logic            q;
    logic [CH_W-1:0] rem;
  } div_step_t;

  // One restoring division step: bring in the next dividend bit and subtract if it fits.
  function automatic div_step_t div_step(input logic [CH_W-1:0] rem,
                                         input logic            nb,
                                         input logic [CH_W-1:0] d);
    logic [CH_W:0] r2;
    logic [CH_W:0] diff;
    div_step_t     st;
    r2   = {rem, nb};
    diff = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      st.q   = 1'b1;
      st.rem = diff[CH_W-1:0];
    end else begin
      st.q   = 1'b0;
      st.rem = r2[CH_W-1:0];
    end
    return st;
  endfunction

endpackage

`default_nettype wire

// ===== src/pscb_channels.sv =====
// Valid/ready channel interfaces for the pixel input word and the blended output word.
`default_nettype none

interface pscb_in_if;
  import pscb_pkg::*;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_in;
  logic [PIX_W-1:0]  shade_pixel;
  logic [MODE_W-1:0] mode;

  modport source (output valid, output pixel_in, output shade_pixel, output mode,
                  input ready);
  modport sink   (input valid, input pixel_in, input shade_pixel, input mode,
                  output ready);
endinterface

interface pscb_out_if;
  import pscb_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

`default_nettype wire

// ===== src/pixel_channel_shade_blend.sv =====
// Top level of the per-channel pixel shade/specular blend.
// Takes one word per clock while the output is not stalled and returns one blended
// pixel per word, in order, through eight divider stages and one output register.
// The pipeline depth is set by the specular divider in each channel lane,
// a restoring divider that resolves two of the sixteen quotient bits per stage.
// Every stage holds its own word, so the input keeps flowing while a finished pixel
// waits at the output until the pipeline is full. Mode 1 multiplies each channel by
// the shader channel and divides by 255; mode 2 computes channel*255/shader, keeps the
// low byte, and gives zero for a zero shader channel; modes 0 and 3 pass the pixel.
`default_nettype none

module pixel_channel_shade_blend
  import pscb_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pscb_in_if.sink    in_i,
  pscb_out_if.source out_o
);

  pipe_ctl_t         ctl;
  logic              in_ready;
  logic              out_valid;
  logic [PIX_W-1:0]  side_pixel;
  logic [MODE_W-1:0] side_mode;
  logic [CH_W-1:0]   shade_q [CHANNELS];
  logic [CH_W-1:0]   spec_q  [CHANNELS];
  logic [PIX_W-1:0]  pixel_out;

  pscb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .pixel_i     (in_i.pixel_in),
    .mode_i      (in_i.mode),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .ctl_o       (ctl),
    .pixel_o     (side_pixel),
    .mode_o      (side_mode)
  );

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic [CH_W-1:0] chan;
    logic [CH_W-1:0] shd;
    // Channels beyond the 32-bit fields read as zero.
    if (i < PIX_CHANNELS) begin : g_in
      assign chan = in_i.pixel_in[i*CH_W +: CH_W];
      assign shd  = in_i.shade_pixel[i*CH_W +: CH_W];
    end else begin : g_zero
      assign chan = '0;
      assign shd  = '0;
    end

    pscb_lane u_lane (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .chan_i    (chan),
      .shade_i   (shd),
      .shade_q_o (shade_q[i]),
      .spec_q_o  (spec_q[i])
    );
  end

  pscb_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .pixel_i   (side_pixel),
    .mode_i    (side_mode),
    .shade_q_i (shade_q),
    .spec_q_i  (spec_q),
    .pixel_o   (pixel_out)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.pixel_out = pixel_out;

endmodule

`default_nettype wire

// ===== src/pscb_ctrl.sv =====
// Pipeline occupancy, ready chain and pixel/mode sideband for the blend pipeline.
`default_nettype none

module pscb_ctrl
  import pscb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [PIX_W-1:0]  pixel_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output pipe_ctl_t         ctl_o,
  output logic [PIX_W-1:0]  pixel_o,
  output logic [MODE_W-1:0] mode_o
);

  logic [DIV_STAGES:0]   valid_q, valid_d;
  logic [DIV_STAGES+1:0] rdy;
  logic [DIV_STAGES:0]   up_valid;
  logic [DIV_STAGES:0]   load;

  logic [PIX_W-1:0]  pix_q  [DIV_STAGES];
  logic [MODE_W-1:0] mode_q [DIV_STAGES];

  // A stage can take a new word when it is empty or its own word moves on.
  always_comb begin
    rdy[DIV_STAGES+1] = out_ready_i;
    for (int k = DIV_STAGES; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    up_valid = {valid_q[DIV_STAGES-1:0], in_valid_i};
    load     = rdy[DIV_STAGES:0] & up_valid;
    for (int k = 0; k <= DIV_STAGES; k++) begin
      valid_d[k] = rdy[k] ? up_valid[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      pix_q[0]  <= pixel_i;
      mode_q[0] <= mode_i;
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (load[k]) begin
        pix_q[k]  <= pix_q[k-1];
        mode_q[k] <= mode_q[k-1];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[DIV_STAGES];
  assign ctl_o.load  = load;
  assign ctl_o.valid = valid_q;
  assign pixel_o     = pix_q[DIV_STAGES-1];
  assign mode_o      = mode_q[DIV_STAGES-1];

  // Input back-pressure only happens when every stage holds a word.
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rdy[0] |-> (&valid_q))
    else $error("input stalled while the pipeline has a free stage");

  // A stage that cannot hand its word on keeps it.
  a_no_word_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($past(valid_q & ~rdy[DIV_STAGES+1:1]) & ~valid_q) == '0))
    else $error("a stalled stage dropped its word");

  // An accepted word occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && rdy[0]) |=> valid_q[0])
    else $error("accepted word did not enter the first stage");

endmodule

`default_nettype wire

// ===== src/pscb_lane.sv =====
// One channel lane: shade product and a pipelined restoring divider for specular.
`default_nettype none

module pscb_lane
  import pscb_pkg::*;
(
  input  logic            clk_i,
  input  pipe_ctl_t       ctl_i,
  input  logic [CH_W-1:0] chan_i,
  input  logic [CH_W-1:0] shade_i,
  output logic [CH_W-1:0] shade_q_o,
  output logic [CH_W-1:0] spec_q_o
);

  logic [NUM_W-1:0] num_q  [DIV_STAGES];
  logic [CH_W-1:0]  rem_q  [DIV_STAGES];
  logic [CH_W-1:0]  quo_q  [DIV_STAGES];
  logic [CH_W-1:0]  div_q  [DIV_STAGES];
  logic [NUM_W-1:0] prod_q [DIV_STAGES];

  logic [NUM_W-1:0] num_d  [DIV_STAGES];
  logic [CH_W-1:0]  rem_d  [DIV_STAGES];
  logic [CH_W-1:0]  quo_d  [DIV_STAGES];
  logic [CH_W-1:0]  div_d  [DIV_STAGES];
  logic [NUM_W-1:0] prod_d [DIV_STAGES];

  logic [NUM_W-1:0] prod_in;
  logic [NUM_W-1:0] num_in;

  // channel*255 is formed as channel*256 - channel.
  assign prod_in = NUM_W'(chan_i) * NUM_W'(shade_i);
  assign num_in  = {chan_i, {CH_W{1'b0}}} - NUM_W'(chan_i);

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [NUM_W-1:0] num_s;
    logic [CH_W-1:0]  rem_s;
    logic [CH_W-1:0]  quo_s;
    logic [CH_W-1:0]  dv_s;
    logic [NUM_W-1:0] prod_s;

    if (k == 0) begin : g_first
      assign num_s  = num_in;
      assign rem_s  = '0;
      assign quo_s  = '0;
      assign dv_s   = shade_i;
      assign prod_s = prod_in;
    end else begin : g_next
      assign num_s  = num_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign quo_s  = quo_q[k-1];
      assign dv_s   = div_q[k-1];
      assign prod_s = prod_q[k-1];
    end

    always_comb begin
      div_step_t        st;
      logic [NUM_W-1:0] num;
      logic [CH_W-1:0]  rem;
      logic [CH_W-1:0]  quo;
      logic [CH_W-1:0]  dv;
      num       = num_s;
      rem       = rem_s;
      quo       = quo_s;
      dv        = dv_s;
      prod_d[k] = prod_s;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        st  = div_step(rem, num[NUM_W-1], dv);
        rem = st.rem;
        quo = {quo[CH_W-2:0], st.q};
        num = {num[NUM_W-2:0], 1'b0};
      end
      num_d[k] = num;
      rem_d[k] = rem;
      quo_d[k] = quo;
      div_d[k] = dv;
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.load[k]) begin
        num_q[k]  <= num_d[k];
        rem_q[k]  <= rem_d[k];
        quo_q[k]  <= quo_d[k];
        div_q[k]  <= div_d[k];
        prod_q[k] <= prod_d[k];
      end
    end
  end

  // Exact product/255 for every 8x8 product: (x + (x >> 8) + 1) >> 8.
  logic [NUM_W:0] shade_sum;
  assign shade_sum = {1'b0, prod_q[DIV_STAGES-1]}
                   + (NUM_W+1)'(prod_q[DIV_STAGES-1] >> CH_W)
                   + (NUM_W+1)'(1);
  assign shade_q_o = shade_sum[CH_W +: CH_W];

  // Only the low quotient byte survives; a zero shader channel gives zero.
  assign spec_q_o = (div_q[DIV_STAGES-1] == '0) ? '0 : quo_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== src/pscb_merge.sv =====
// Merge stage: picks each lane's result by mode and registers the output word.
`default_nettype none

module pscb_merge
  import pscb_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic              clk_i,
  input  pipe_ctl_t         ctl_i,
  input  logic [PIX_W-1:0]  pixel_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [CH_W-1:0]   shade_q_i [CHANNELS],
  input  logic [CH_W-1:0]   spec_q_i  [CHANNELS],
  output logic [PIX_W-1:0]  pixel_o
);

  logic [PIX_W-1:0] blend;
  logic [PIX_W-1:0] pixel_d, pixel_q;

  // Bytes without a lane stay zero in the blending modes.
  for (genvar j = 0; j < PIX_CHANNELS; j++) begin : g_byte
    if (j < CHANNELS) begin : g_lane
      assign blend[j*CH_W +: CH_W] = (mode_e'(mode_i) == MODE_SHADE) ? shade_q_i[j]
                                                                     : spec_q_i[j];
    end else begin : g_empty
      assign blend[j*CH_W +: CH_W] = '0;
    end
  end

  always_comb begin
    case (mode_e'(mode_i))
      MODE_SHADE, MODE_SPECULAR: pixel_d = blend;
      MODE_NONE, MODE_BOTH:      pixel_d = pixel_i;
      default:                   pixel_d = pixel_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[DIV_STAGES]) begin
      pixel_q <= pixel_d;
    end
  end

  assign pixel_o = pixel_q;

endmodule

`default_nettype wire

// ===== dv/pixel_channel_shade_blend_test.sv =====
// Self-checking testbench for the per-channel pixel shade and specular blend.
`default_nettype none

module pixel_channel_shade_blend_test;
  import pscb_pkg::*;

  localparam int unsigned FULL_CHANNEL = (1 << CH_W) - 1;
  localparam int unsigned RANDOM_WORDS = 550;
  localparam int unsigned HOLD_AFTER   = 120;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 30;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] shd;
    mode_e            mode;
  } blend_word_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  pscb_in_if  in_ch ();
  pscb_out_if out_ch ();

  pixel_channel_shade_blend uut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  logic             send_valid = 1'b0;
  logic [PIX_W-1:0] send_pix   = '0;
  logic [PIX_W-1:0] send_shd   = '0;
  mode_e            send_mode  = MODE_NONE;
  logic             take_ready = 1'b0;

  assign in_ch.valid       = send_valid;
  assign in_ch.pixel_in    = send_pix;
  assign in_ch.shade_pixel = send_shd;
  assign in_ch.mode        = send_mode;
  assign out_ch.ready      = take_ready;

  blend_word_t      pending_words[$];
  logic [PIX_W-1:0] expected_pixels[$];
  int unsigned      accepted_count = 0;
  int unsigned      error_count    = 0;
  int unsigned      cycle_count    = 0;
  int unsigned      send_gap       = 0;
  int unsigned      take_gap       = 0;
  int unsigned      hold_left      = 0;
  logic             hold_active    = 1'b0;
  logic             hold_done      = 1'b0;
  logic             steady;

  // A quarter of each repeating cycle_count window runs with no idling on either side.
  assign steady = (cycle_count % 512) < 128;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [PIX_W-1:0] blend_pixel(input logic [PIX_W-1:0] pix,
                                                   input logic [PIX_W-1:0] shd,
                                                   input mode_e            mode);
    logic [PIX_W-1:0] res;
    int unsigned      c;
    int unsigned      s;
    int unsigned      q;
    int unsigned      i;
    res = '0;
    if (mode == MODE_NONE || mode == MODE_BOTH) return pix;
    for (i = 0; i < PIX_CHANNELS; i++) begin
      c = pix[CH_W*i +: CH_W];
      s = shd[CH_W*i +: CH_W];
      if (mode == MODE_SHADE) q = (c * s) / FULL_CHANNEL;
      else if (s == 0) q = 0;
      else q = (c * FULL_CHANNEL) / s;
      // Specular quotients above one byte wrap rather than saturate.
      res[CH_W*i +: CH_W] = q[CH_W-1:0];
    end
    return res;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Bias channels toward zero, full scale and tiny shader values.
  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    int unsigned      i;
    for (i = 0; i < PIX_CHANNELS; i++) begin
      case ($urandom_range(0, 7))
        0: p[CH_W*i +: CH_W] = '0;
        1: p[CH_W*i +: CH_W] = '1;
        2: p[CH_W*i +: CH_W] = CH_W'($urandom_range(1, 3));
        default: p[CH_W*i +: CH_W] = CH_W'($urandom_range(0, FULL_CHANNEL));
      endcase
    end
    return p;
  endfunction

  task automatic add_word(input logic [PIX_W-1:0] pix, input logic [PIX_W-1:0] shd,
                          input mode_e mode);
    blend_word_t w;
    w.pix  = pix;
    w.shd  = shd;
    w.mode = mode;
    pending_words.push_back(w);
  endtask

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  always @(posedge clk_i or negedge rst_n) begin : drive_words
    blend_word_t w;
    if (!rst_n) begin
      send_valid <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (send_valid && in_ch.ready) begin
        expected_pixels.push_back(blend_pixel(send_pix, send_shd, send_mode));
        accepted_count <= accepted_count + 1;
      end
      if (send_valid && !in_ch.ready) begin
        // Hold the offered word until it is taken.
      end else if (send_gap != 0) begin
        send_gap   <= send_gap - 1;
        send_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        send_valid <= 1'b1;
        send_pix   <= w.pix;
        send_shd   <= w.shd;
        send_mode  <= w.mode;
        send_gap   <= (steady || hold_active) ? 0 : idle_len();
      end else begin
        send_valid <= 1'b0;
      end
    end
  end

  // One long output stall so the pipeline fills and pushes back on the input.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      hold_active <= 1'b0;
      hold_done   <= 1'b0;
      hold_left   <= 0;
    end else if (hold_active) begin
      if (hold_left == 0) hold_active <= 1'b0;
      else hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
      hold_active <= 1'b1;
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
    end
  end

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      take_ready <= 1'b0;
      take_gap   <= 0;
    end else if (hold_active) begin
      take_ready <= 1'b0;
    end else if (take_gap != 0) begin
      take_gap   <= take_gap - 1;
      take_ready <= 1'b0;
    end else begin
      take_ready <= 1'b1;
      take_gap   <= steady ? 0 : idle_len();
    end
  end

  always @(posedge clk_i) begin : check_pixels
    logic [PIX_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel_out: no word expected, actual %h", out_ch.pixel_out);
        error_count <= error_count + 1;
      end else begin
        want = expected_pixels.pop_front();
        if (out_ch.pixel_out !== want) begin
          $error("pixel_out mismatch: expected %h, actual %h", want, out_ch.pixel_out);
          error_count <= error_count + 1;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    // Extremes of each field in every mode.
    add_word('0, '0, MODE_NONE);
    add_word('1, '1, MODE_NONE);
    add_word('1, '1, MODE_BOTH);
    add_word(32'h1234_5678, 32'h0000_0000, MODE_BOTH);
    add_word('1, '1, MODE_SHADE);
    add_word('0, '1, MODE_SHADE);
    add_word('1, '0, MODE_SHADE);
    add_word(32'h80FF_7F01, 32'hFF80_0201, MODE_SHADE);
    add_word('1, '1, MODE_SPECULAR);
    add_word('0, '1, MODE_SPECULAR);
    // Zero shader channels give zero, whole word and single lanes.
    add_word('1, '0, MODE_SPECULAR);
    add_word('1, 32'h00FF_0100, MODE_SPECULAR);
    add_word(32'hA5A5_A5A5, 32'h0100_0001, MODE_SPECULAR);
    // Large quotients wrap to their low byte.
    add_word('1, 32'h0101_0101, MODE_SPECULAR);
    add_word(32'h8040_2010, 32'h0102_0304, MODE_SPECULAR);
    add_word(32'h0102_0304, 32'hFFFE_FDFC, MODE_SPECULAR);
    add_word(32'hFF01_7FFE, 32'h0203_FF7F, MODE_SPECULAR);
    add_word(32'h5555_AAAA, 32'hAAAA_5555, MODE_SHADE);
    for (n = 0; n < RANDOM_WORDS; n++) begin
      add_word(rand_pixel(), rand_pixel(), mode_e'($urandom_range(0, 3)));
    end

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || send_valid) @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("pixel_channel_shade_blend_test: done, clean");
    end else begin
      $display("pixel_channel_shade_blend_test: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("pixel_channel_shade_blend_test: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
